// ----- rtl/fnps_pkg.sv -----
// Shared constants and controller/datapath interface types for the prime sieve.
// Used by fnps_ctrl, fnps_datapath and first_n_primes_sieve_top.
package fnps_pkg;

   // Sieve and request sizing
   localparam int MAP_SIZE   = 512;
   localparam int MAX_PRIMES = 64;
   localparam int COUNT_W    = 8;                          // request count field
   localparam int PRIME_W    = $clog2(MAP_SIZE);           // 9, prime field
   localparam int ADDR_W     = PRIME_W + 1;                // room for stepping past the end
   localparam int NUM_W      = $clog2(MAX_PRIMES + 1);     // 7, holds 0..MAX_PRIMES
   localparam int ROOT_W     = 5;                          // base value 2..23

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start;       // latch count, clear address
      logic load_empty;  // put the empty result in the output register
      logic clr_step;    // write 0 at address, address + 1
      logic init_base;   // base value <= 2
      logic rd_base;     // read the map at the base value
      logic mark_start;  // address <= base * base
      logic mark_step;   // write 1 at address, address + base
      logic next_base;   // base value + 1
      logic scan_start;  // address <= 2
      logic rd_addr;     // read the map at address
      logic load_prime;  // put address in the output register as a prime
      logic addr_inc;    // address + 1
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic small_req;   // incoming count is 0 or 1
      logic clr_done;    // clearing is at the final entry
      logic base_done;   // base * base has reached the sieve size
      logic rd_bit;      // registered map bit
      logic mark_done;   // marking address is past the end
      logic out_taken;   // output item is accepted this cycle
      logic out_last;    // output item carries the last flag
   } status_type;

endpackage

// ----- rtl/fnps_ctrl.sv -----
// Controller state machine for the prime sieve: clear, mark, scan, emit.
// Depends on fnps_pkg for the command and status types.
module fnps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fnps_pkg::status_type status,
   output fnps_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CLEAR    = 3'd1;
   localparam logic [2:0] ST_BASE     = 3'd2;
   localparam logic [2:0] ST_BASE_CHK = 3'd3;
   localparam logic [2:0] ST_MARK     = 3'd4;
   localparam logic [2:0] ST_SCAN_RD  = 3'd5;
   localparam logic [2:0] ST_SCAN_CHK = 3'd6;
   localparam logic [2:0] ST_OUT      = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Only the idle state takes a new item
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.small_req) begin
                  cmd.load_empty = 1'b1;
                  state_in       = ST_OUT;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) begin
               cmd.init_base = 1'b1;
               state_in      = ST_BASE;
            end
         end
         ST_BASE: begin
            if (status.base_done) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN_RD;
            end else begin
               cmd.rd_base = 1'b1;
               state_in    = ST_BASE_CHK;
            end
         end
         ST_BASE_CHK: begin
            if (!status.rd_bit) begin
               cmd.mark_start = 1'b1;
               state_in       = ST_MARK;
            end else begin
               cmd.next_base = 1'b1;
               state_in      = ST_BASE;
            end
         end
         ST_MARK: begin
            if (status.mark_done) begin
               cmd.next_base = 1'b1;
               state_in      = ST_BASE;
            end else begin
               cmd.mark_step = 1'b1;
            end
         end
         ST_SCAN_RD: begin
            cmd.rd_addr = 1'b1;
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (!status.rd_bit) begin
               cmd.load_prime = 1'b1;
               state_in       = ST_OUT;
            end else begin
               cmd.addr_inc = 1'b1;
               state_in     = ST_SCAN_RD;
            end
         end
         ST_OUT: begin
            if (status.out_taken) begin
               if (status.out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.addr_inc = 1'b1;
                  state_in     = ST_SCAN_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/fnps_datapath.sv -----
// Datapath for the prime sieve: bitmap memory, address and base counters,
// request count and the output register. Depends on fnps_pkg.
module fnps_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  fnps_pkg::cmd_type                  cmd,
   output fnps_pkg::status_type               status,
   input  logic [fnps_pkg::COUNT_W-1:0]       req_count,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fnps_pkg::PRIME_W-1:0]       rsp_prime,
   output logic                               rsp_empty_res,
   output logic                               rsp_last
);

   // Bitmap: one bit per value, set when composite
   logic mem [fnps_pkg::MAP_SIZE];
   logic rd_bit_ff;

   logic [fnps_pkg::ADDR_W-1:0] addr_ff;
   logic [fnps_pkg::ADDR_W-1:0] addr_in;
   logic [fnps_pkg::ROOT_W-1:0] base_ff;
   logic [fnps_pkg::ROOT_W-1:0] base_in;
   logic [fnps_pkg::NUM_W-1:0]  want_ff;
   logic [fnps_pkg::NUM_W-1:0]  want_in;
   logic [fnps_pkg::NUM_W-1:0]  sent_ff;
   logic [fnps_pkg::NUM_W-1:0]  sent_in;

   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic [fnps_pkg::PRIME_W-1:0] out_prime_ff;
   logic [fnps_pkg::PRIME_W-1:0] out_prime_in;
   logic                        out_empty_ff;
   logic                        out_empty_in;
   logic                        out_last_ff;
   logic                        out_last_in;

   logic [fnps_pkg::ADDR_W-1:0]  base_sq;
   logic [fnps_pkg::ADDR_W-1:0]  base_ext;
   logic [fnps_pkg::PRIME_W-1:0] rd_addr;
   logic                         wr_en;
   logic                         wr_data;
   logic                         rd_en;
   logic                         out_taken;
   logic                         is_final;

   assign base_ext  = fnps_pkg::ADDR_W'(base_ff);
   assign base_sq   = base_ext * base_ext;
   assign out_taken = out_valid_ff && !rsp_stall;
   assign is_final  = ((sent_ff + 1'b1) == want_ff);

   // Memory port control
   assign wr_en   = cmd.clr_step || cmd.mark_step;
   assign wr_data = cmd.mark_step;
   assign rd_en   = cmd.rd_base || cmd.rd_addr;
   assign rd_addr = cmd.rd_base ? fnps_pkg::PRIME_W'(base_ff)
                                : addr_ff[fnps_pkg::PRIME_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff[fnps_pkg::PRIME_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_bit_ff <= mem[rd_addr];
      end
   end

   // Status back to the controller
   always_comb begin
      status.small_req = (req_count <= fnps_pkg::COUNT_W'(1));
      status.clr_done  = (addr_ff == fnps_pkg::ADDR_W'(fnps_pkg::MAP_SIZE - 1));
      status.base_done = (base_sq >= fnps_pkg::ADDR_W'(fnps_pkg::MAP_SIZE));
      status.rd_bit    = rd_bit_ff;
      status.mark_done = (addr_ff >= fnps_pkg::ADDR_W'(fnps_pkg::MAP_SIZE));
      status.out_taken = out_taken;
      status.out_last  = out_last_ff;
   end

   // Address, base and counters
   always_comb begin
      addr_in = addr_ff;
      base_in = base_ff;
      want_in = want_ff;
      sent_in = sent_ff;
      priority if (cmd.start) begin
         addr_in = '0;
         sent_in = '0;
         if (req_count > fnps_pkg::COUNT_W'(fnps_pkg::MAX_PRIMES)) begin
            want_in = fnps_pkg::NUM_W'(fnps_pkg::MAX_PRIMES);
         end else begin
            want_in = req_count[fnps_pkg::NUM_W-1:0];
         end
      end else if (cmd.clr_step || cmd.addr_inc) begin
         addr_in = addr_ff + 1'b1;
      end else if (cmd.mark_start) begin
         addr_in = base_sq;
      end else if (cmd.mark_step) begin
         addr_in = addr_ff + base_ext;
      end else if (cmd.scan_start) begin
         addr_in = fnps_pkg::ADDR_W'(2);
      end else if (cmd.load_prime) begin
         sent_in = sent_ff + 1'b1;
      end else begin
         addr_in = addr_ff;
      end
      if (cmd.init_base) begin
         base_in = fnps_pkg::ROOT_W'(2);
      end else if (cmd.next_base) begin
         base_in = base_ff + 1'b1;
      end
   end

   // Output register: holds an item until it is taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_prime_in = out_prime_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;
      if (out_taken) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load_empty) begin
         out_valid_in = 1'b1;
         out_prime_in = '0;
         out_empty_in = 1'b1;
         out_last_in  = 1'b1;
      end else if (cmd.load_prime) begin
         out_valid_in = 1'b1;
         out_prime_in = addr_ff[fnps_pkg::PRIME_W-1:0];
         out_empty_in = 1'b0;
         out_last_in  = is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         addr_ff      <= '0;
         base_ff      <= '0;
         want_ff      <= '0;
         sent_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         addr_ff      <= addr_in;
         base_ff      <= base_in;
         want_ff      <= want_in;
         sent_ff      <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      out_prime_ff <= out_prime_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_prime     = out_prime_ff;
   assign rsp_empty_res = out_empty_ff;
   assign rsp_last      = out_last_ff;

endmodule

// ----- rtl/first_n_primes_sieve_top.sv -----
// A count of 0 or 1 gives its one empty item the cycle after acceptance.
// Otherwise the bitmap is cleared entry by entry, then marked from each unmarked base
// (one bitmap write per cycle), then scanned with a read state and a check state per
// value checked; each prime found waits in the output register until it is taken.
// Throughput: one request at a time; the controller takes a new request only when idle.
// Reset: synchronous, clears controller and counters; the bitmap is cleared per sieve run.
module first_n_primes_sieve_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fnps_pkg::COUNT_W-1:0]  req_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fnps_pkg::PRIME_W-1:0]  rsp_prime,
   output logic                          rsp_empty_res,
   output logic                          rsp_last
);

   fnps_pkg::cmd_type    cmd;
   fnps_pkg::status_type status;

   // Sequencer
   fnps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Bitmap, counters and output register
   fnps_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_count     (req_count),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_prime     (rsp_prime),
      .rsp_empty_res (rsp_empty_res),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- test/tb_first_n_primes_sieve_top.sv -----
// Self-checking testbench for first_n_primes_sieve_top: directed request table,
// then random request counts under varying sender/receiver idling and one long output hold.
// Depends on fnps_pkg and the sieve RTL only.
module tb_first_n_primes_sieve_top;

   typedef struct packed {
      logic [fnps_pkg::PRIME_W-1:0] prime;
      logic                         empty_res;
      logic                         last;
   } prime_result_type;

   typedef struct packed {
      logic [fnps_pkg::COUNT_W-1:0] count;
      logic                         fixed;     // expected result typed in below
      prime_result_type             want;
   } request_row_type;

   localparam prime_result_type EMPTY_RESULT = '{prime: '0, empty_res: 1'b1, last: 1'b1};
   localparam prime_result_type NO_RESULT    = '0;
   localparam int N_DIRECTED = 19;
   localparam int N_RANDOM   = 271;
   localparam int HOLD_CYCLES = 3000;

   // Directed requests: small counts, every count bit, saturation, full range
   localparam request_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{8'd0,   1'b1, EMPTY_RESULT},
      '{8'd1,   1'b1, EMPTY_RESULT},
      '{8'd2,   1'b0, NO_RESULT},
      '{8'd3,   1'b0, NO_RESULT},
      '{8'd4,   1'b0, NO_RESULT},
      '{8'd5,   1'b0, NO_RESULT},
      '{8'd10,  1'b0, NO_RESULT},
      '{8'd31,  1'b0, NO_RESULT},
      '{8'd63,  1'b0, NO_RESULT},
      '{8'd64,  1'b0, NO_RESULT},
      '{8'd65,  1'b0, NO_RESULT},
      '{8'd127, 1'b0, NO_RESULT},
      '{8'd128, 1'b0, NO_RESULT},
      '{8'd170, 1'b0, NO_RESULT},
      '{8'd85,  1'b0, NO_RESULT},
      '{8'd255, 1'b0, NO_RESULT},
      '{8'd0,   1'b1, EMPTY_RESULT},
      '{8'd2,   1'b0, NO_RESULT},
      '{8'd1,   1'b1, EMPTY_RESULT}
   };

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [fnps_pkg::COUNT_W-1:0] req_count = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [fnps_pkg::PRIME_W-1:0] rsp_prime;
   logic                         rsp_empty_res;
   logic                         rsp_last;

   prime_result_type              expected_primes [$];
   bit [fnps_pkg::MAP_SIZE-1:0]   sieve_map;
   int                            error_count = 0;
   int                            requests_sent = 0;
   int                            empty_requests = 0;
   int                            saturated_requests = 0;
   int                            results_checked = 0;
   int                            send_idle_pct = 28;
   int                            rcv_idle_pct = 50;
   bit                            hold_arm = 1'b0;
   bit                            hold_used = 1'b0;
   int                            hold_left = 0;

   first_n_primes_sieve_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_count     (req_count),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_prime     (rsp_prime),
      .rsp_empty_res (rsp_empty_res),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      error_count++;
   endtask

   // Sieve a fresh map; queue the first min(n, MAX_PRIMES) primes, or an empty item if n < 2
   function automatic void predict_primes(input logic [fnps_pkg::COUNT_W-1:0] count);
      int unsigned      wanted;
      int unsigned      found;
      prime_result_type item;
      wanted = (count > fnps_pkg::MAX_PRIMES) ? fnps_pkg::MAX_PRIMES : count;
      sieve_map = '0;
      for (int i = 2; i * i < fnps_pkg::MAP_SIZE; i++) begin
         if (!sieve_map[i]) begin
            for (int j = i * i; j < fnps_pkg::MAP_SIZE; j += i) sieve_map[j] = 1'b1;
         end
      end
      found = 0;
      if (wanted >= 2) begin
         for (int i = 2; i < fnps_pkg::MAP_SIZE && found < wanted; i++) begin
            if (!sieve_map[i]) begin
               item = '{prime: fnps_pkg::PRIME_W'(i), empty_res: 1'b0, last: 1'b0};
               expected_primes = {expected_primes, item};
               found++;
            end
         end
      end
      if (found == 0) begin
         expected_primes = {expected_primes, EMPTY_RESULT};
      end else begin
         // the final prime of the request carries the last flag
         expected_primes[expected_primes.size() - 1].last = 1'b1;
      end
   endfunction

   // Offer one request, idling first at random; returns at the accepting edge
   task automatic offer_request(input logic [fnps_pkg::COUNT_W-1:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_count <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      if (count <= 1) empty_requests++;
      if (count >= fnps_pkg::MAX_PRIMES) saturated_requests++;
   endtask

   // Mostly small and mid counts, a share of empty and saturating ones
   function automatic logic [fnps_pkg::COUNT_W-1:0] pick_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15) return fnps_pkg::COUNT_W'($urandom_range(1, 0));
      if (r < 60) return fnps_pkg::COUNT_W'($urandom_range(20, 2));
      if (r < 80) return fnps_pkg::COUNT_W'($urandom_range(64, 21));
      return fnps_pkg::COUNT_W'($urandom_range(255, 65));
   endfunction

   // Receiver: random stall, plus one long hold-off when armed
   always @(posedge clock) begin
      if (hold_arm && !hold_used) begin
         hold_left = HOLD_CYCLES;
         hold_used = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Result checker against the oldest expectation
   always @(posedge clock) begin
      prime_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_primes.size() == 0) begin
            report_mismatch($sformatf("unexpected result prime=%0d empty=%0b last=%0b",
                                      rsp_prime, rsp_empty_res, rsp_last));
         end else begin
            want = expected_primes.pop_front();
            if (rsp_prime !== want.prime)
               report_mismatch($sformatf("prime %0d, expected %0d", rsp_prime, want.prime));
            if (rsp_empty_res !== want.empty_res)
               report_mismatch($sformatf("empty_res %0b, expected %0b",
                                         rsp_empty_res, want.empty_res));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b after prime %0d, expected %0b",
                                         rsp_last, want.prime, want.last));
         end
      end
   end

   // Stimulus
   initial begin
      logic [fnps_pkg::COUNT_W-1:0] count;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table, sender idles 28%, receiver 50%
      for (int row = 0; row < N_DIRECTED; row++) begin
         offer_request(DIRECTED_ROWS[row].count);
         if (DIRECTED_ROWS[row].fixed) begin
            expected_primes = {expected_primes, DIRECTED_ROWS[row].want};
         end else begin
            predict_primes(DIRECTED_ROWS[row].count);
         end
      end

      // random counts in three idling phases
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 3) begin
            send_idle_pct = 50;
            rcv_idle_pct = 28;
         end else if (n == 2 * N_RANDOM / 3) begin
            send_idle_pct = 0;
            rcv_idle_pct = 0;
            hold_arm = 1'b1;
         end
         count = pick_count();
         offer_request(count);
         predict_primes(count);
      end
      req_valid <= 1'b0;

      while (expected_primes.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (expected_primes.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_primes.size()));

      $display("Covered %0d requests: %0d empty, %0d at or above the %0d-prime limit.",
               requests_sent, empty_requests, saturated_requests, fnps_pkg::MAX_PRIMES);
      $display("Checked %0d results under mixed stalls and one %0d-cycle output hold.",
               results_checked, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
